/* sv/bhtk_pkg.sv */
// ----------------------------------------------------------------------------
// bhtk_pkg
// shared types and constants of the byte histogram with top-k report
// ----------------------------------------------------------------------------
`default_nettype none

package bhtk_pkg;

    localparam int TOP_K_DEF      = 10;
    localparam int COUNT_BITS_DEF = 32;

    localparam int SYM_W    = 8;
    localparam int NUM_SYM  = 256;
    localparam int DIST_W   = 9;
    localparam int RANK_W   = 4;
    localparam int TOTAL_W  = 5;
    localparam int OCC_W    = 32;
    localparam int OUT_D_W  = 56;

    localparam logic OP_COUNT  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [DIST_W-1:0] distinct;
        logic              look_valid;
    } t_cnt_stat;

endpackage

`default_nettype wire

/* sv/bhtk_ram.sv */
// ----------------------------------------------------------------------------
// bhtk_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bhtk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/bhtk_count.sv */
// ----------------------------------------------------------------------------
// bhtk_count
// read-modify-write of the count table with forwarding, entry valid bits
// and the distinct tally
// ----------------------------------------------------------------------------
`default_nettype none

module bhtk_count #(
    parameter int COUNT_BITS = bhtk_pkg::COUNT_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [bhtk_pkg::SYM_W-1:0] i_sym,
    input  wire logic [COUNT_BITS-1:0]      i_rdata,
    input  wire logic                       i_clear,
    input  wire logic [bhtk_pkg::SYM_W-1:0] i_look_addr,
    output logic                            o_we,
    output logic      [bhtk_pkg::SYM_W-1:0] o_waddr,
    output logic      [COUNT_BITS-1:0]      o_wdata,
    output bhtk_pkg::t_cnt_stat             o_stat
);

    import bhtk_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  r_s2_valid;
    logic [SYM_W-1:0]      r_s2_sym;
    logic                  r_fwd_hit;
    logic [COUNT_BITS-1:0] r_fwd_val;
    logic [NUM_SYM-1:0]    r_valid;
    logic [DIST_W-1:0]     r_distinct;

    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;

    always_comb begin
        if (r_fwd_hit) begin
            old_cnt = r_fwd_val;
        end else if (r_valid[r_s2_sym]) begin
            old_cnt = i_rdata;
        end else begin
            old_cnt = '0;
        end
        new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_valid    <= '0;
            r_distinct <= '0;
        end else begin
            r_s2_valid <= i_accept;
            r_fwd_hit  <= i_accept && r_s2_valid && (r_s2_sym == i_sym);
            if (i_clear) begin
                r_valid    <= '0;
                r_distinct <= '0;
            end else if (r_s2_valid) begin
                r_valid[r_s2_sym] <= 1'b1;
                if (old_cnt == '0) begin
                    r_distinct <= r_distinct + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_sym  <= i_sym;
        r_fwd_val <= new_cnt;
    end

    assign o_we              = r_s2_valid;
    assign o_waddr           = r_s2_sym;
    assign o_wdata           = new_cnt;
    assign o_stat.distinct   = r_distinct;
    assign o_stat.look_valid = r_valid[i_look_addr];

endmodule

`default_nettype wire

/* sv/bhtk_scan.sv */
// ----------------------------------------------------------------------------
// bhtk_scan
// report sequencer: one pass over the count table per rank, picks the
// largest count that ranks below the previous pick and drives the result
// register
// ----------------------------------------------------------------------------
`default_nettype none

module bhtk_scan #(
    parameter int TOP_K      = bhtk_pkg::TOP_K_DEF,
    parameter int COUNT_BITS = bhtk_pkg::COUNT_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    input  wire logic                         i_op,
    input  wire logic [COUNT_BITS-1:0]        i_rdata,
    input  wire bhtk_pkg::t_cnt_stat          i_stat,
    input  wire logic                         i_m_tready,
    output logic                              o_idle,
    output logic      [bhtk_pkg::SYM_W-1:0]   o_scan_addr,
    output logic      [bhtk_pkg::SYM_W-1:0]   o_look_addr,
    output logic                              o_clear,
    output logic                              o_m_tvalid,
    output logic      [bhtk_pkg::OUT_D_W-1:0] o_m_tdata,
    output logic                              o_m_tuser,
    output logic                              o_m_tlast
);

    import bhtk_pkg::*;

    localparam logic [SYM_W-1:0] SIGN_FLIP = {1'b1, {(SYM_W-1){1'b0}}};

    t_state                r_state,    n_state;
    logic [SYM_W:0]        r_idx,      n_idx;
    logic                  r_cmp_valid, n_cmp_valid;
    logic [SYM_W-1:0]      r_cmp_sym,  n_cmp_sym;
    logic                  r_cmp_last, n_cmp_last;
    logic [COUNT_BITS-1:0] r_best_cnt, n_best_cnt;
    logic [SYM_W-1:0]      r_best_sym, n_best_sym;
    logic [COUNT_BITS-1:0] r_prev_cnt, n_prev_cnt;
    logic [SYM_W-1:0]      r_prev_sym, n_prev_sym;
    logic [RANK_W-1:0]     r_rank,     n_rank;
    logic [TOTAL_W-1:0]    r_total,    n_total;
    logic                  r_empty,    n_empty;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_D_W-1:0]    r_out_data, n_out_data;
    logic                  r_out_user, n_out_user;
    logic                  r_out_last, n_out_last;

    logic [OCC_W-1:0]      occ;
    logic                  out_free;
    logic                  is_last;
    logic                  clear;
    logic [COUNT_BITS-1:0] look_cnt;
    logic                  below_prev;

    generate
        if (COUNT_BITS > OCC_W) begin : g_occ_sat
            assign occ = (|r_best_cnt[COUNT_BITS-1:OCC_W]) ? '1 : r_best_cnt[OCC_W-1:0];
        end else begin : g_occ_ext
            assign occ = OCC_W'(r_best_cnt);
        end
    endgenerate

    assign out_free    = !r_out_valid || i_m_tready;
    assign is_last     = r_empty || (({1'b0, r_rank} + 1'b1) == r_total);
    assign o_scan_addr = r_idx[SYM_W-1:0] ^ {1'b1, {(SYM_W-1){1'b0}}};
    assign o_look_addr = r_cmp_sym;

    // order: count descending, then signed char order ascending
    assign look_cnt   = i_stat.look_valid ? i_rdata : '0;
    assign below_prev = (r_rank == '0) || (look_cnt < r_prev_cnt) ||
                        ((look_cnt == r_prev_cnt) &&
                         ((r_cmp_sym ^ SIGN_FLIP) > (r_prev_sym ^ SIGN_FLIP)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cmp_sym  <= n_cmp_sym;
        r_cmp_last <= n_cmp_last;
        r_best_cnt <= n_best_cnt;
        r_best_sym <= n_best_sym;
        r_prev_cnt <= n_prev_cnt;
        r_prev_sym <= n_prev_sym;
        r_rank     <= n_rank;
        r_total    <= n_total;
        r_empty    <= n_empty;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cmp_valid = 1'b0;
        n_cmp_sym   = r_cmp_sym;
        n_cmp_last  = r_cmp_last;
        n_best_cnt  = r_best_cnt;
        n_best_sym  = r_best_sym;
        n_prev_cnt  = r_prev_cnt;
        n_prev_sym  = r_prev_sym;
        n_rank      = r_rank;
        n_total     = r_total;
        n_empty     = r_empty;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        clear       = 1'b0;
        o_idle      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_s_tvalid && (i_op == OP_REPORT)) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_total    = (i_stat.distinct < DIST_W'(TOP_K)) ?
                             TOTAL_W'(i_stat.distinct) : TOTAL_W'(TOP_K);
                n_rank     = '0;
                n_idx      = '0;
                n_best_cnt = '0;
                n_best_sym = '0;
                n_empty    = (i_stat.distinct == '0);
                n_state    = (i_stat.distinct == '0) ? ST_RESULT : ST_SCAN;
            end
            ST_SCAN: begin
                if (!r_idx[SYM_W]) begin
                    n_cmp_valid = 1'b1;
                    n_cmp_sym   = o_scan_addr;
                    n_cmp_last  = (r_idx[SYM_W-1:0] == '1);
                    n_idx       = r_idx + 1'b1;
                end
                if (r_cmp_valid) begin
                    if (below_prev && (look_cnt > r_best_cnt)) begin
                        n_best_cnt = look_cnt;
                        n_best_sym = r_cmp_sym;
                    end
                    if (r_cmp_last) begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_data           = '0;
                    n_out_data[8:0]      = i_stat.distinct;
                    n_out_data[12:9]     = r_rank;
                    n_out_data[20:13]    = r_best_sym;
                    n_out_data[52:21]    = occ;
                    n_out_user           = !r_empty;
                    n_out_last           = is_last;
                    if (is_last) begin
                        clear   = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_prev_cnt = r_best_cnt;
                        n_prev_sym = r_best_sym;
                        n_rank     = r_rank + 1'b1;
                        n_idx      = '0;
                        n_best_cnt = '0;
                        n_best_sym = '0;
                        n_state    = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_clear    = clear;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

/* sv/byte_histogram_top_k.sv */
// counting: one byte per cycle while no report runs, each count written back the cycle after its transaction
// report: a setup state, then per rank a full scan of the table and a result state,
//   each scan going through the single ram read port
// the result register lets new bytes enter while the last result waits
// reset (synchronous) clears the entry valid bits and tally at once, no clearing pass
// ----------------------------------------------------------------------------
// byte_histogram_top_k
// 256-entry byte histogram in ram with a top-k ranking report
// ----------------------------------------------------------------------------
`default_nettype none

module byte_histogram_top_k #(
    parameter int TOP_K      = bhtk_pkg::TOP_K_DEF,
    parameter int COUNT_BITS = bhtk_pkg::COUNT_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [bhtk_pkg::SYM_W-1:0]   i_s_tdata,  // symbol
    input  wire logic                         i_s_tuser,  // operation
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    // distinct_symbols, rank, top_symbol, occurrences, zero pad
    output logic      [bhtk_pkg::OUT_D_W-1:0] o_m_tdata,
    output logic                              o_m_tuser,  // entry_valid
    output logic                              o_m_tlast   // last_of_run
);

    import bhtk_pkg::*;

    logic                  idle;
    logic                  cnt_accept;
    logic [SYM_W-1:0]      scan_addr;
    logic [SYM_W-1:0]      look_addr;
    logic [SYM_W-1:0]      raddr;
    logic                  clear;
    logic                  we;
    logic [SYM_W-1:0]      waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [COUNT_BITS-1:0] rdata;
    t_cnt_stat             stat;

    assign o_s_tready = idle;
    assign cnt_accept = i_s_tvalid && idle && (i_s_tuser == OP_COUNT);
    assign raddr      = idle ? i_s_tdata : scan_addr;

    bhtk_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_SYM)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bhtk_count #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (cnt_accept),
        .i_sym       (i_s_tdata),
        .i_rdata     (rdata),
        .i_clear     (clear),
        .i_look_addr (look_addr),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_stat      (stat)
    );

    bhtk_scan #(
        .TOP_K      (TOP_K),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_op        (i_s_tuser),
        .i_rdata     (rdata),
        .i_stat      (stat),
        .i_m_tready  (i_m_tready),
        .o_idle      (idle),
        .o_scan_addr (scan_addr),
        .o_look_addr (look_addr),
        .o_clear     (clear),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

/* sv/bhtk_checker.sv */
// ----------------------------------------------------------------------------
// bhtk_checker
// port-level checks of the result stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module bhtk_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_s_tready,
    input wire logic                         o_m_tvalid,
    input wire logic                         i_m_tready,
    input wire logic [bhtk_pkg::OUT_D_W-1:0] o_m_tdata,
    input wire logic                         o_m_tuser,
    input wire logic                         o_m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // empty report is a single closing transaction
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast && (o_m_tdata[8:0] == 9'd0))
        else $error("empty report malformed");

    // a ranked byte was seen at least once
    a_occ_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> (o_m_tdata[52:21] != 32'd0) &&
                                   (o_m_tdata[8:0] != 9'd0))
        else $error("ranked byte with zero count");

    // rank steps by one within a report
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=>
        !o_m_tvalid || (o_m_tdata[12:9] == $past(o_m_tdata[12:9]) + 4'd1))
        else $error("rank sequence broken");

    // no input taken while a report is still running
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input ready during report");

endmodule

bind byte_histogram_top_k bhtk_checker u_bhtk_checker (.*);

`default_nettype wire

/* test/byte_histogram_top_k_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_histogram_top_k_tb
// checks the byte histogram counts and the top-k report of every run against
// an independent ranking computed from the accepted bytes, under random
// sender gaps, receiver stalls and one long output hold-off
// ----------------------------------------------------------------------------
module byte_histogram_top_k_tb;

    import bhtk_pkg::*;

    localparam int          ITEMS_TARGET  = 350;
    localparam int          LONG_HOLD     = 4000;
    localparam int          DRAIN_CYCLES  = 3000;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          DIST_LSB      = 0;
    localparam int          RANK_LSB      = DIST_W;
    localparam int          SYM_LSB       = DIST_W + RANK_W;
    localparam int          OCC_LSB       = DIST_W + RANK_W + SYM_W;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 1;
    localparam longint unsigned OCC_MAX   = (64'd1 << OCC_W) - 1;

    typedef struct {
        logic [DIST_W-1:0] distinct;
        logic [RANK_W-1:0] rank;
        logic [SYM_W-1:0]  sym;
        logic [OCC_W-1:0]  occ;
        logic              valid;
        logic              last;
    } t_ranked_entry;

    class histogram_board;
        longint unsigned tally[NUM_SYM];
        int unsigned     distinct_seen;
        t_ranked_entry   pending_ranks[$];
        int              errors;
        int              results_checked;
        int              results_predicted;

        function void rank_and_clear();
            bit              taken[NUM_SYM];
            int              total;
            longint unsigned best;
            logic [SYM_W-1:0] best_sym;
            logic [SYM_W-1:0] b;
            t_ranked_entry   e;
            taken = '{default: 1'b0};
            if (distinct_seen == 0) begin
                e.distinct = '0;
                e.rank     = '0;
                e.sym      = '0;
                e.occ      = '0;
                e.valid    = 1'b0;
                e.last     = 1'b1;
                pending_ranks.push_back(e);
                results_predicted++;
            end else begin
                total = (distinct_seen < TOP_K_DEF) ? distinct_seen : TOP_K_DEF;
                for (int k = 0; k < total; k++) begin
                    best     = 0;
                    best_sym = '0;
                    // signed char order: 0x80..0xff first, then 0x00..0x7f
                    for (int i = 0; i < NUM_SYM; i++) begin
                        b = SYM_W'(i + 128);
                        if (!taken[b] && tally[b] > best) begin
                            best     = tally[b];
                            best_sym = b;
                        end
                    end
                    taken[best_sym] = 1'b1;
                    e.distinct = DIST_W'(distinct_seen);
                    e.rank     = RANK_W'(k);
                    e.sym      = best_sym;
                    e.occ      = OCC_W'((best > OCC_MAX) ? OCC_MAX : best);
                    e.valid    = 1'b1;
                    e.last     = (k == total - 1);
                    pending_ranks.push_back(e);
                    results_predicted++;
                end
            end
            tally         = '{default: 0};
            distinct_seen = 0;
        endfunction

        function void note_input(logic op, logic [SYM_W-1:0] sym);
            if (op == OP_COUNT) begin
                if (tally[sym] == 0)
                    distinct_seen++;
                if (tally[sym] < COUNT_MAX)
                    tally[sym]++;
            end else begin
                rank_and_clear();
            end
        endfunction

        function void compare_field(string field, longint unsigned want,
                                    longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_D_W-1:0] data, logic valid, logic last);
            t_ranked_entry e;
            if (pending_ranks.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data %h valid %b last %b",
                         $time, data, valid, last);
                errors++;
                return;
            end
            e = pending_ranks.pop_front();
            results_checked++;
            compare_field("distinct_symbols", e.distinct, data[DIST_LSB +: DIST_W]);
            compare_field("rank", e.rank, data[RANK_LSB +: RANK_W]);
            compare_field("top_symbol", e.sym, data[SYM_LSB +: SYM_W]);
            compare_field("occurrences", e.occ, data[OCC_LSB +: OCC_W]);
            compare_field("entry_valid", e.valid, valid);
            compare_field("last_of_run", e.last, last);
        endfunction
    endclass

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [SYM_W-1:0]   s_tdata  = '0;   // symbol
    logic               s_tuser  = 1'b0; // operation
    logic               m_tready = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [OUT_D_W-1:0] m_tdata;         // distinct, rank, top_symbol, occurrences, pad
    logic               m_tuser;         // entry_valid
    logic               m_tlast;         // last_of_run

    histogram_board histo = new();

    int burst_left    = 0;
    int items_sent    = 0;
    int reports_sent  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_mode    = 0;
    int mode_left     = 0;
    int phase_cnt     = 0;
    int cycle_count   = 0;

    byte_histogram_top_k i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[byte_histogram_top_k] ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk) begin
        phase_cnt <= (phase_cnt == 6) ? 0 : phase_cnt + 1;
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 9) == 0);
                default: m_tready <= (phase_cnt < 3);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            histo.check_result(m_tdata, m_tuser, m_tlast);
    end

    task automatic send_item(input logic op, input logic [SYM_W-1:0] sym);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= sym;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        histo.note_input(op, sym);
        burst_left--;
        items_sent++;
        if (op == OP_REPORT)
            reports_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (histo.pending_ranks.size() != 0) @(posedge clk);
    endtask

    task automatic send_full_sweep();
        logic [SYM_W-1:0] order[NUM_SYM];
        logic [SYM_W-1:0] tmp;
        int               j;
        for (int i = 0; i < NUM_SYM; i++)
            order[i] = SYM_W'(i);
        for (int i = NUM_SYM - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < NUM_SYM; i++)
            send_item(OP_COUNT, order[i]);
        repeat ($urandom_range(0, 20))
            send_item(OP_COUNT, SYM_W'($urandom));
    endtask

    task automatic send_random_text(input int kind, input int len);
        logic [SYM_W-1:0] base;
        int               span;
        logic [SYM_W-1:0] sym;
        base = SYM_W'($urandom);
        span = $urandom_range(1, 12);
        repeat (len) begin
            case (kind)
                1, 2:       sym = SYM_W'($urandom);
                3, 4, 5, 6: sym = base + SYM_W'($urandom_range(0, span));
                7, 8:       sym = base + SYM_W'(($urandom_range(0, 3) == 0) ?
                                  $urandom_range(0, 15) : $urandom_range(0, 2));
                default:    sym = SYM_W'($urandom_range(8'h20, 8'h7e));
            endcase
            send_item(OP_COUNT, sym);
        end
    endtask

    initial begin
        int frame_idx;
        int kind;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty histogram
        send_item(OP_REPORT, 8'h00);
        // equal counts across the signed char boundary
        send_item(OP_COUNT, 8'hff);
        send_item(OP_COUNT, 8'h00);
        send_item(OP_COUNT, 8'h7f);
        send_item(OP_COUNT, 8'h80);
        send_item(OP_COUNT, 8'h01);
        send_item(OP_COUNT, 8'h01);
        send_item(OP_REPORT, 8'hff);
        // more distinct bytes than ranks
        for (int s = 0; s < 12; s++)
            send_item(OP_COUNT, SYM_W'(s * 21 + 3));
        send_item(OP_REPORT, 8'h55);
        // report right after a report sees a cleared histogram
        send_item(OP_REPORT, 8'haa);

        frame_idx = 0;
        while (items_sent < ITEMS_TARGET || frame_idx < 5) begin
            kind = $urandom_range(0, 9);
            if (frame_idx == 1) begin
                hold_requests <= hold_requests + 1;
                send_random_text(1, 30);
            end else if (frame_idx == 2) begin
                wait_drained();
                send_random_text(3, 25);
            end else if (frame_idx == 3) begin
                send_full_sweep();
            end else if (kind != 0) begin
                send_random_text(kind, $urandom_range(1, 40));
            end
            send_item(OP_REPORT, SYM_W'($urandom));
            frame_idx++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d items including %0d report requests", items_sent, reports_sent);
        $display("checked %0d ranked results, %0d mismatches", histo.results_checked,
                 histo.errors);
        if (histo.errors == 0 && histo.pending_ranks.size() == 0) begin
            $display("[byte_histogram_top_k] OK");
        end else begin
            $display("[byte_histogram_top_k] ERROR");
        end
        $finish;
    end

endmodule
